/* rtl/llwd_pkg.sv */
// shared constants, types and helpers for the least loaded worker dispatcher
package llwd_pkg;

   localparam int MAX_WORKERS = 8;
   localparam int COUNT_WIDTH = 16;
   localparam int IDX_W       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int NUM_W       = $clog2(MAX_WORKERS + 1);
   localparam int WORKER_W    = 3;
   localparam int LOAD_W      = 16;
   localparam int CFG_W       = 4;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 24;

   localparam logic CMD_ACQUIRE = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef logic [IDX_W-1:0]       idx_type;
   typedef logic [NUM_W-1:0]       num_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic load;     // take the request transfer and set up the scan
      logic step;     // examine one worker
      logic commit;   // update the count and write the response register
   } dp_cmd_type;

   typedef struct packed {
      logic is_release;
      logic scan_done;
      logic out_free;
   } dp_stat_type;

   // clamp the written worker count into 1..MAX_WORKERS
   function automatic num_type active_count(input logic [CFG_W-1:0] value);
      if (value == '0) begin
         return NUM_W'(1);
      end else if (32'(value) > MAX_WORKERS) begin
         return NUM_W'(MAX_WORKERS);
      end else begin
         return NUM_W'(value);
      end
   endfunction

endpackage

/* rtl/llwd_ctrl.sv */
// controller state machine: accept, scan, update
module llwd_ctrl
   import llwd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = (req_tuser == CMD_RELEASE) ? ST_UPD : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            // hold until the response register can take the result
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_scan_only_acquire: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !stat.is_release)
      else $error("scan running for a release");

   a_release_skips_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == CMD_RELEASE) |=> (state_ff == ST_UPD))
      else $error("release did not go straight to update");

endmodule

/* rtl/llwd_dp.sv */
// datapath: per-worker counts, scan registers, pointer and response register
module llwd_dp
   import llwd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CFG_W-1:0]      csr_wdata,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   count_type             count_ff [MAX_WORKERS];
   num_type               n_ff;
   idx_type               ptr_ff;
   idx_type               scan_ff;
   num_type               step_ff;
   idx_type               best_ff;
   count_type             best_val_ff;
   logic                  is_rel_ff;
   logic [WORKER_W-1:0]   worker_ff;
   logic                  rsp_valid_ff;
   logic [WORKER_W-1:0]   rsp_who_ff;
   logic [LOAD_W-1:0]     rsp_load_ff;
   logic                  rsp_err_ff;

   idx_type               rd_idx;
   count_type             rd_val;
   logic                  worker_ok;
   logic                  hit_zero;
   logic                  take;
   logic                  scan_last;
   idx_type               scan_next;
   idx_type               ptr_next;
   logic                  wr_en;
   count_type             new_val;
   logic                  upd_err;
   logic [LOAD_W-1:0]     upd_load;
   logic [WORKER_W-1:0]   upd_who;

   // single read port into the count registers
   assign rd_idx    = !cmd.commit ? scan_ff : (is_rel_ff ? idx_type'(worker_ff) : best_ff);
   assign rd_val    = count_ff[rd_idx];
   assign worker_ok = (32'(worker_ff) < MAX_WORKERS);

   assign hit_zero  = (rd_val == '0);
   assign take      = hit_zero || (step_ff == '0) || (rd_val < best_val_ff);
   assign scan_last = ((step_ff + NUM_W'(1)) == n_ff);
   assign scan_next = ((NUM_W'(scan_ff) + NUM_W'(1)) == n_ff) ? '0 : scan_ff + idx_type'(1);
   assign ptr_next  = ((NUM_W'(ptr_ff) + NUM_W'(1)) == n_ff) ? '0 : ptr_ff + idx_type'(1);

   always_comb begin
      wr_en    = 1'b0;
      new_val  = rd_val;
      upd_err  = 1'b0;
      upd_load = LOAD_W'(rd_val);
      upd_who  = is_rel_ff ? worker_ff : WORKER_W'(best_ff);
      if (!is_rel_ff) begin
         if (rd_val == '1) begin
            upd_err = 1'b1;
         end else begin
            wr_en   = 1'b1;
            new_val = rd_val + count_type'(1);
         end
         upd_load = LOAD_W'(new_val);
      end else if (!worker_ok || hit_zero) begin
         upd_err  = 1'b1;
         upd_load = '0;
      end else begin
         wr_en    = 1'b1;
         new_val  = rd_val - count_type'(1);
         upd_load = LOAD_W'(new_val);
      end
   end

   assign stat.is_release = is_rel_ff;
   assign stat.scan_done  = hit_zero || scan_last;
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_WORKERS; i++) begin
            count_ff[i] <= '0;
         end
         n_ff         <= active_count(CFG_W'(8));
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            n_ff   <= active_count(csr_wdata);
            ptr_ff <= '0;
         end else if (cmd.commit && !is_rel_ff) begin
            ptr_ff <= ptr_next;
         end
         if (cmd.commit && wr_en) begin
            count_ff[rd_idx] <= new_val;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_rel_ff <= (req_tuser == CMD_RELEASE);
         worker_ff <= req_tdata[WORKER_W-1:0];
         scan_ff   <= ptr_ff;
         step_ff   <= '0;
         best_ff   <= ptr_ff;
      end
      if (cmd.step) begin
         if (take) begin
            best_ff     <= scan_ff;
            best_val_ff <= rd_val;
         end
         scan_ff <= scan_next;
         step_ff <= step_ff + NUM_W'(1);
      end
      if (cmd.commit) begin
         rsp_who_ff  <= upd_who;
         rsp_load_ff <= upd_load;
         rsp_err_ff  <= upd_err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - WORKER_W - LOAD_W){1'b0}}, rsp_load_ff, rsp_who_ff};
   assign rsp_tuser  = rsp_err_ff;

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      NUM_W'(ptr_ff) < n_ff)
      else $error("rotation pointer beyond active workers");

   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result written over an untaken response");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

endmodule

/* rtl/least_loaded_worker_dispatcher_core.sv */
// top level: least loaded worker dispatcher, controller plus datapath
// an acquire examines k workers in turn (1..workers_in_use, stopping at the first idle
//   worker), then updates the count and registers its response; a release skips the scan
// and goes straight to the update; a new request transfer is taken only once the
//   controller is back in idle, and the update waits while an earlier response is untaken;
//   reset clears counts, pointer, sets 8 workers
module least_loaded_worker_dispatcher_core
   import llwd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CFG_W-1:0]      csr_wdata,   // workers_in_use
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [2:0] worker, rest zero
   input  logic                  req_tuser,   // [0] cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [2:0] chosen_worker, [18:3] load_after
   output logic                  rsp_tuser    // [0] error
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   llwd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (dp_stat),
      .cmd        (dp_cmd)
   );

   llwd_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (dp_cmd),
      .stat       (dp_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* bench/least_loaded_worker_dispatcher_core_tb.sv */
// self-checking testbench for the least loaded worker dispatcher core
`timescale 1ns / 100ps

module least_loaded_worker_dispatcher_core_tb;
   import llwd_pkg::*;

   localparam count_type COUNT_MAX      = '1;
   localparam int        WATCHDOG_LIMIT = 1000;

   typedef struct packed {
      logic [WORKER_W-1:0] worker;
      logic [LOAD_W-1:0]   load;
      logic                err_flag;
   } job_outcome_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CFG_W-1:0]      csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [2:0] worker, rest zero
   logic                  req_tuser  = 1'b0; // [0] cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [2:0] chosen_worker, [18:3] load_after
   logic                  rsp_tuser;         // [0] error

   // dispatcher state as the bench sees it
   count_type        load_level [MAX_WORKERS];
   int               scan_origin    = 0;
   logic [CFG_W-1:0] worker_setting = CFG_W'(8);

   job_outcome_type expected_outcomes [$];
   int              mismatches   = 0;
   int              quiet_cycles = 0;
   int              stall_left   = 0;
   bit              idle_on      = 1'b1;

   least_loaded_worker_dispatcher_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int active_workers();
      if (worker_setting == '0) begin
         return 1;
      end else if (int'(worker_setting) > MAX_WORKERS) begin
         return MAX_WORKERS;
      end else begin
         return int'(worker_setting);
      end
   endfunction

   function automatic job_outcome_type apply_job(input logic cmd,
                                                 input logic [WORKER_W-1:0] worker);
      job_outcome_type o;
      int              n;
      int              origin;
      int              pick;
      int              idx;
      count_type       lowest;
      n          = active_workers();
      o.err_flag = 1'b0;
      if (cmd == CMD_ACQUIRE) begin
         origin = scan_origin % n;
         pick   = origin;
         lowest = load_level[origin];
         for (int j = 0; j < n; j++) begin
            idx = (origin + j) % n;
            // an idle worker ends the scan at once
            if (load_level[idx] == '0) begin
               pick = idx;
               break;
            end
            if (load_level[idx] < lowest) begin
               lowest = load_level[idx];
               pick   = idx;
            end
         end
         if (load_level[pick] == COUNT_MAX) begin
            o.err_flag = 1'b1;
         end else begin
            load_level[pick] = load_level[pick] + count_type'(1);
         end
         scan_origin = (origin + 1) % n;
         o.worker    = WORKER_W'(pick);
         o.load      = LOAD_W'(load_level[pick]);
      end else begin
         o.worker = worker;
         if (load_level[worker] == '0) begin
            o.load     = '0;
            o.err_flag = 1'b1;
         end else begin
            load_level[worker] = load_level[worker] - count_type'(1);
            o.load             = LOAD_W'(load_level[worker]);
         end
      end
      return o;
   endfunction

   // valid is left high after a transfer so back-to-back items never toggle it
   task automatic send_job(input logic cmd, input logic [WORKER_W-1:0] worker);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_DATA_W'(worker);
      do @(posedge clock); while (!req_tready);
      expected_outcomes.push_back(apply_job(cmd, worker));
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_workers(input logic [CFG_W-1:0] value);
      settle();
      csr_we         <= 1'b1;
      csr_wdata      <= value;
      worker_setting  = value;
      scan_origin     = 0;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic test_rotation_and_release();
      for (int k = 0; k < 6; k++) begin
         send_job(CMD_ACQUIRE, (k % 2 == 0) ? WORKER_W'(0) : WORKER_W'(7));
      end
      send_job(CMD_RELEASE, WORKER_W'(7));   // nothing outstanding
      send_job(CMD_RELEASE, WORKER_W'(0));
      send_job(CMD_RELEASE, WORKER_W'(0));
      send_job(CMD_ACQUIRE, WORKER_W'(3));
      write_workers(CFG_W'(3));
      send_job(CMD_RELEASE, WORKER_W'(5));   // worker outside the active set
      for (int k = 0; k < 6; k++) begin
         send_job(CMD_ACQUIRE, WORKER_W'(k));
      end
      // leave the smallest count late in the scan order
      send_job(CMD_RELEASE, WORKER_W'(2));
      send_job(CMD_RELEASE, WORKER_W'(2));
      send_job(CMD_ACQUIRE, WORKER_W'(1));
      send_job(CMD_ACQUIRE, WORKER_W'(6));
   endtask

   task automatic test_worker_count_limits();
      write_workers(CFG_W'(0));
      send_job(CMD_ACQUIRE, WORKER_W'(4));
      send_job(CMD_ACQUIRE, WORKER_W'(2));
      send_job(CMD_RELEASE, WORKER_W'(0));
      write_workers(CFG_W'(15));
      for (int k = 0; k < 3; k++) begin
         send_job(CMD_ACQUIRE, WORKER_W'(k));
      end
      write_workers(CFG_W'(9));
      send_job(CMD_ACQUIRE, WORKER_W'(5));
      write_workers(CFG_W'(8));
      send_job(CMD_ACQUIRE, WORKER_W'(1));
      send_job(CMD_RELEASE, WORKER_W'(7));
   endtask

   task automatic test_random_traffic(input int total);
      int                  n;
      logic                cmd;
      logic [WORKER_W-1:0] worker;
      for (int k = 0; k < total; k++) begin
         if (k % 100 == 0) begin
            write_workers(CFG_W'($urandom_range(0, 15)));
         end
         if (k == 450) begin
            settle();
         end
         if (k == total - 150) begin
            idle_on = 1'b0;
         end
         n   = active_workers();
         cmd = ($urandom_range(0, 99) < 55) ? CMD_ACQUIRE : CMD_RELEASE;
         if (cmd == CMD_RELEASE && $urandom_range(0, 3) != 0) begin
            worker = WORKER_W'($urandom_range(0, n - 1));
         end else begin
            worker = WORKER_W'($urandom);
         end
         send_job(cmd, worker);
      end
   endtask

   task automatic test_single_worker();
      idle_on = 1'b0;
      write_workers(CFG_W'(1));
      send_job(CMD_ACQUIRE, WORKER_W'(0));
      send_job(CMD_ACQUIRE, WORKER_W'(7));
      send_job(CMD_RELEASE, WORKER_W'(0));
      send_job(CMD_ACQUIRE, WORKER_W'(3));
      send_job(CMD_ACQUIRE, WORKER_W'(4));
      send_job(CMD_RELEASE, WORKER_W'(6));
   endtask

   // result side back-pressure in bursts of random length
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      job_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_outcomes.size() == 0) begin
            $error("unexpected result transfer: chosen_worker %0d, load_after %0d",
                   rsp_tdata[2:0], rsp_tdata[18:3]);
            mismatches++;
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_tdata[2:0] !== want.worker) begin
               $error("chosen_worker: expected %0d, got %0d", want.worker, rsp_tdata[2:0]);
               mismatches++;
            end
            if (rsp_tdata[18:3] !== want.load) begin
               $error("load_after: expected %0d, got %0d", want.load, rsp_tdata[18:3]);
               mismatches++;
            end
            if (rsp_tuser !== want.err_flag) begin
               $error("error: expected %0d, got %0d", want.err_flag, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int k = 0; k < MAX_WORKERS; k++) begin
         load_level[k] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_rotation_and_release();
      test_worker_count_limits();
      test_random_traffic(850);
      test_single_worker();
      settle();
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/llwd_pkg.sv
rtl/llwd_ctrl.sv
rtl/llwd_dp.sv
rtl/least_loaded_worker_dispatcher_core.sv
bench/least_loaded_worker_dispatcher_core_tb.sv
